// ----- hw/rtl/utf16_to_utf8_transcoder_unit_defines.svh -----
// Assertion macros shared by the transcoder checker.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UTFX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utfx assertion failed");

// Next-cycle implication, disabled during reset.
`define UTFX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utfx assertion failed");

`endif

// ----- hw/rtl/utfx_pkg.sv -----
// Types, constants and encoding functions of the UTF-16 to UTF-8 transcoder.
package utfx_pkg;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_string;
    } t_out_item;

    localparam logic [5:0]  HIGH_TAG  = 6'h36;
    localparam logic [5:0]  LOW_TAG   = 6'h37;
    localparam logic [20:0] REPL_CP   = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE = 21'h010000;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // One queued job holds up to two code points and their byte counts.
    typedef struct packed {
        logic [20:0] cp0;
        logic [2:0]  len0;
        logic [20:0] cp1;
        logic [2:0]  len1;
        logic        is_last;
    } t_job;

    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= 21'h00007F) begin
            len = LEN_1;
        end else if (cp <= 21'h0007FF) begin
            len = LEN_2;
        end else if (cp <= 21'h00FFFF) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        case (len)
            LEN_1: b = cp[7:0];
            LEN_2: begin
                case (idx)
                    2'd0:    b = LEAD2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/utfx_fifo.sv -----
// Small first-in first-out queue of jobs between the front and the back.
module utfx_fifo #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/utfx_front.sv -----
// Front end: accepts code units, pairs surrogates and builds encoding jobs.
module utfx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  utfx_pkg::t_in_item i_in_data,
    input  logic              i_queue_full,
    output logic              o_in_stall,
    output logic              o_push,
    output utfx_pkg::t_job    o_job
);
    import utfx_pkg::*;

    logic        r_high_pending;
    logic [9:0]  r_high_bits;
    logic        n_high_pending;
    logic [9:0]  n_high_bits;
    logic [15:0] cu;
    logic        last;
    logic        is_high;
    logic        is_low;
    logic        accept;
    logic [20:0] second_cp;
    logic [2:0]  second_len;
    t_job        job;

    always_comb begin
        cu      = i_in_data.code_unit;
        last    = i_in_data.is_last;
        is_high = (cu[15:10] == HIGH_TAG);
        is_low  = (cu[15:10] == LOW_TAG);
        accept  = i_in_valid && !i_queue_full;

        if (is_high) begin
            second_cp  = REPL_CP;
            second_len = last ? LEN_3 : LEN_NONE;
        end else if (is_low) begin
            second_cp  = REPL_CP;
            second_len = LEN_3;
        end else begin
            second_cp  = {5'b00000, cu};
            second_len = cp_len({5'b00000, cu});
        end

        job.is_last = last;
        if (r_high_pending && is_low) begin
            job.cp0  = SUPP_BASE + {1'b0, r_high_bits, cu[9:0]};
            job.len0 = LEN_4;
            job.cp1  = REPL_CP;
            job.len1 = LEN_NONE;
        end else if (r_high_pending) begin
            job.cp0  = REPL_CP;
            job.len0 = LEN_3;
            job.cp1  = second_cp;
            job.len1 = second_len;
        end else begin
            job.cp0  = second_cp;
            job.len0 = second_len;
            job.cp1  = REPL_CP;
            job.len1 = LEN_NONE;
        end

        n_high_pending = is_high && !last;
        n_high_bits    = is_high ? cu[9:0] : r_high_bits;
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = accept && (job.len0 != LEN_NONE);
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_high_bits    <= '0;
        end else if (accept) begin
            r_high_pending <= n_high_pending;
            r_high_bits    <= n_high_bits;
        end
    end

endmodule

// ----- hw/rtl/utfx_back.sv -----
// Back end: turns queued jobs into UTF-8 bytes, one byte per cycle while the output is not stalled.
module utfx_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  utfx_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    output utfx_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import utfx_pkg::*;

    logic        r_busy;
    t_job        r_job;
    logic        r_sel;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [20:0] cur_cp;
    logic [2:0]  cur_len;
    logic        end_cp;
    logic        final_byte;
    logic        advance;
    t_out_item   n_out;

    always_comb begin
        cur_cp     = r_sel ? r_job.cp1 : r_job.cp0;
        cur_len    = r_sel ? r_job.len1 : r_job.len0;
        end_cp     = ({1'b0, r_idx} == (cur_len - 3'd1));
        final_byte = end_cp && (r_sel || (r_job.len1 == LEN_NONE));
        advance    = r_busy && (!r_out_valid || !i_out_stall);
        o_pop      = i_job_valid && (!r_busy || (advance && final_byte));

        n_out.out_byte      = enc_byte(cur_cp, cur_len, r_idx);
        n_out.last_of_run   = final_byte;
        n_out.end_of_string = final_byte && r_job.is_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sel       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (o_pop) begin
                r_busy <= 1'b1;
                r_sel  <= 1'b0;
                r_idx  <= '0;
            end else if (advance) begin
                if (final_byte) begin
                    r_busy <= 1'b0;
                end else if (end_cp) begin
                    r_sel <= 1'b1;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/utf16_to_utf8_transcoder_unit.sv -----
// The first byte of an item passes the job queue, the back end's job register and the
// output register in turn. Throughput: one output byte per cycle while the output is not
// stalled; the byte-wide output register sets this rate.
// A job queue of QUEUE_DEPTH entries lets input be taken while the output is stalled.
// Reset is synchronous and active low; it empties the queue and drops any held surrogate.
module utf16_to_utf8_transcoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  utfx_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output utfx_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import utfx_pkg::*;

    localparam int JOB_W = $bits(t_job);

    logic             push;
    t_job             push_job;
    logic             queue_full;
    logic             queue_valid;
    logic [JOB_W-1:0] queue_data;
    logic             pop;

    utfx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    utfx_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (queue_data),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    utfx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (t_job'(queue_data)),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- hw/rtl/utfx_checker.sv -----
// Port-level checker for the transcoder, bound to the top level.
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module utfx_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input utfx_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    `UTFX_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    `UTFX_ASSERT_NOW(a_eos_ends_run, o_out_valid && o_out_data.end_of_string, o_out_data.last_of_run)

    `UTFX_ASSERT_NOW(a_ascii_single, o_out_valid && !o_out_data.out_byte[7], o_out_data.last_of_run)

    `UTFX_ASSERT_NEXT(a_run_continues, o_out_valid && !i_out_stall && !o_out_data.last_of_run, o_out_valid)

endmodule

bind utf16_to_utf8_transcoder_unit utfx_checker u_checker (.*);
